// ===== hw/rtl/nmea_sfc_pkg.sv =====
// nmea_sfc_pkg: shared types and codes for the nmea sentence framer/checker
// no dependencies; used by the interfaces, the update logic and the top level
`default_nettype none

package nmea_sfc_pkg;

   // configuration of the framer
   localparam int CHANNELS   = 4;
   localparam int CHAN_W     = 2;
   localparam int MAX_LEN    = 128;
   localparam int PREFIX_LEN = 7;

   // sentence type codes
   localparam logic [2:0] TYPE_OTHER = 3'd0;
   localparam logic [2:0] TYPE_GGA   = 3'd1;
   localparam logic [2:0] TYPE_VTG   = 3'd2;
   localparam logic [2:0] TYPE_RMC   = 3'd3;
   localparam logic [2:0] TYPE_GLL   = 3'd4;

   // verdict codes, valid on the last item of a sentence
   localparam logic [2:0] STATUS_UNTYPED  = 3'd0;
   localparam logic [2:0] STATUS_GLL_DROP = 3'd1;
   localparam logic [2:0] STATUS_SUM_OK   = 3'd2;
   localparam logic [2:0] STATUS_SUM_BAD  = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH = 3'd4;
   localparam logic [2:0] STATUS_OVERLONG = 3'd5;

   // framing state of one channel, one memory entry
   typedef struct packed {
      logic       in_sentence;
      logic [7:0] char_count;
      logic [7:0] running_xor;
      logic [1:0] after_star_pos;
      logic       star_seen;
      logic [7:0] wanted_sum;
      logic       hex_ok;
      logic [2:0] type_code;
      logic       prefix_match;
   } chan_state_type;

   // outcome of one byte
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [2:0] sentence_type;
      logic [2:0] status;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nmea_sfc_if.sv =====
// nmea_sfc_req_if and nmea_sfc_rsp_if: valid/ready channels of the framer
// depends on nmea_sfc_pkg for the channel width
`default_nettype none

interface nmea_sfc_req_if;
   logic                             valid;
   logic                             ready;
   logic [nmea_sfc_pkg::CHAN_W-1:0]  channel;
   logic [7:0]                       rx_byte;

   modport source (output valid, output channel, output rx_byte, input ready);
   modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

interface nmea_sfc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [nmea_sfc_pkg::CHAN_W-1:0]  out_channel;
   logic [7:0]                       data_byte;
   logic                             first;
   logic                             last;
   logic [2:0]                       sentence_type;
   logic [2:0]                       status;

   modport source (output valid, output out_channel, output data_byte, output first,
                   output last, output sentence_type, output status, input ready);
   modport sink   (input valid, input out_channel, input data_byte, input first,
                   input last, input sentence_type, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nmea_sfc_update.sv =====
// nmea_sfc_update: next framing state and result for one byte of one channel
// depends on nmea_sfc_pkg
`default_nettype none

module nmea_sfc_update (
   input  wire nmea_sfc_pkg::chan_state_type cur,
   input  wire logic [7:0]                   rx_byte,
   output nmea_sfc_pkg::chan_state_type      nxt,
   output nmea_sfc_pkg::result_type          res
);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   logic [8:0] count;
   logic       hex_valid;
   logic [3:0] hex_nib;
   logic       pfx_ok;
   logic [2:0] pfx_type;
   logic       pfx_active;

   assign count      = {1'b0, cur.char_count} + 9'd1;
   assign pfx_active = cur.prefix_match && (cur.char_count >= 8'd1) &&
                       (cur.char_count < 8'(nmea_sfc_pkg::PREFIX_LEN));

   // hex digit decode, either case
   always_comb begin
      hex_valid = 1'b1;
      hex_nib   = 4'd0;
      if (rx_byte >= "0" && rx_byte <= "9") begin
         hex_nib = 4'(rx_byte - "0");
      end else if (rx_byte >= "A" && rx_byte <= "F") begin
         hex_nib = 4'(rx_byte - "A" + 8'd10);
      end else if (rx_byte >= "a" && rx_byte <= "f") begin
         hex_nib = 4'(rx_byte - "a" + 8'd10);
      end else begin
         hex_valid = 1'b0;
      end
   end

   // prefix match by position, narrowing the type
   always_comb begin
      pfx_ok   = 1'b0;
      pfx_type = cur.type_code;
      case (cur.char_count)
         8'd1: pfx_ok = (rx_byte == "G");
         8'd2: pfx_ok = (rx_byte == "P") || (rx_byte == "N");
         8'd3: begin
            if (rx_byte == "G") begin
               pfx_type = nmea_sfc_pkg::TYPE_GGA;
               pfx_ok   = 1'b1;
            end else if (rx_byte == "V") begin
               pfx_type = nmea_sfc_pkg::TYPE_VTG;
               pfx_ok   = 1'b1;
            end else if (rx_byte == "R") begin
               pfx_type = nmea_sfc_pkg::TYPE_RMC;
               pfx_ok   = 1'b1;
            end
         end
         8'd4: begin
            if (cur.type_code == nmea_sfc_pkg::TYPE_GGA && rx_byte == "G") begin
               pfx_ok = 1'b1;
            end else if (cur.type_code == nmea_sfc_pkg::TYPE_GGA && rx_byte == "L") begin
               pfx_type = nmea_sfc_pkg::TYPE_GLL;
               pfx_ok   = 1'b1;
            end else if (cur.type_code == nmea_sfc_pkg::TYPE_VTG && rx_byte == "T") begin
               pfx_ok = 1'b1;
            end else if (cur.type_code == nmea_sfc_pkg::TYPE_RMC && rx_byte == "M") begin
               pfx_ok = 1'b1;
            end
         end
         8'd5: pfx_ok = (cur.type_code == nmea_sfc_pkg::TYPE_GGA && rx_byte == "A") ||
                        (cur.type_code == nmea_sfc_pkg::TYPE_VTG && rx_byte == "G") ||
                        (cur.type_code == nmea_sfc_pkg::TYPE_RMC && rx_byte == "C") ||
                        (cur.type_code == nmea_sfc_pkg::TYPE_GLL && rx_byte == "L");
         8'd6: pfx_ok = (rx_byte == ",");
         default: pfx_ok = 1'b0;
      endcase
   end

   // framing, checksum capture and verdict
   always_comb begin
      nxt = cur;
      res = '0;
      if (!cur.in_sentence) begin
         // hunting: only a dollar opens a sentence
         if (rx_byte == CH_DOLLAR) begin
            nxt              = '0;
            nxt.in_sentence  = 1'b1;
            nxt.char_count   = 8'd1;
            nxt.prefix_match = 1'b1;
            res.valid        = 1'b1;
            res.first        = 1'b1;
         end
      end else begin
         res.valid = 1'b1;
         if (pfx_active) begin
            nxt.prefix_match = pfx_ok;
            nxt.type_code    = pfx_ok ? pfx_type : nmea_sfc_pkg::TYPE_OTHER;
         end

         // xor span ends at the first star, two hex digits follow
         if (cur.star_seen) begin
            if (cur.after_star_pos < 2'd2) begin
               if (!hex_valid) begin
                  nxt.hex_ok = 1'b0;
               end else begin
                  nxt.wanted_sum = {cur.wanted_sum[3:0], hex_nib};
               end
               nxt.after_star_pos = cur.after_star_pos + 2'd1;
            end
         end else if (rx_byte == CH_STAR) begin
            nxt.star_seen      = 1'b1;
            nxt.after_star_pos = 2'd0;
            nxt.hex_ok         = 1'b1;
            nxt.wanted_sum     = 8'd0;
         end else begin
            nxt.running_xor = cur.running_xor ^ rx_byte;
         end

         nxt.char_count = count[7:0];
         if (nxt.prefix_match && count >= 9'(nmea_sfc_pkg::PREFIX_LEN)) begin
            res.sentence_type = nxt.type_code;
         end

         if (count >= 9'(nmea_sfc_pkg::MAX_LEN)) begin
            res.last        = 1'b1;
            res.status      = nmea_sfc_pkg::STATUS_OVERLONG;
            nxt.in_sentence = 1'b0;
         end else if (rx_byte == CH_LF) begin
            res.last        = 1'b1;
            nxt.in_sentence = 1'b0;
            if (res.sentence_type == nmea_sfc_pkg::TYPE_OTHER) begin
               res.status = nmea_sfc_pkg::STATUS_UNTYPED;
            end else if (res.sentence_type == nmea_sfc_pkg::TYPE_GLL) begin
               res.status = nmea_sfc_pkg::STATUS_GLL_DROP;
            end else if (!nxt.star_seen || nxt.after_star_pos < 2'd2 || !nxt.hex_ok) begin
               res.status = nmea_sfc_pkg::STATUS_SUM_BAD;
            end else if (nxt.running_xor == nxt.wanted_sum) begin
               res.status = nmea_sfc_pkg::STATUS_SUM_OK;
            end else begin
               res.status = nmea_sfc_pkg::STATUS_MISMATCH;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sentence_framer_checker.sv =====
// nmea_sentence_framer_checker: per-channel nmea framing and checksum check
// depends on nmea_sfc_pkg, nmea_sfc_req_if, nmea_sfc_rsp_if and nmea_sfc_update
//
//   port     dir  modport  carries
//   req_bus  in   sink     channel, rx_byte
//   rsp_bus  out  source   out_channel, data_byte, first, last, sentence_type, status
//
// one byte per cycle while the output is not stalled; the result is loaded into the output
// register after the update stage (state memory read at the accepting edge, update and
// write-back when the update stage retires). a same-channel byte accepted while the
// previous one retires takes the updated state from a forwarding register.
// synchronous reset clears the pipeline and the per-channel valid bits; an entry
// not yet written reads as zero, so no clearing pass is needed.
// a stalled output holds the update stage, and that holds the input.
`default_nettype none

module nmea_sentence_framer_checker (
   input  wire logic            clock,
   input  wire logic            reset,
   nmea_sfc_req_if.sink         req_bus,
   nmea_sfc_rsp_if.source       rsp_bus
);

   localparam int CW = nmea_sfc_pkg::CHAN_W;

   // state memory and entry valid bits
   nmea_sfc_pkg::chan_state_type state_mem [nmea_sfc_pkg::CHANNELS];
   logic [nmea_sfc_pkg::CHANNELS-1:0] entry_valid_ff;

   // update stage
   logic                           s1_valid_ff;
   logic [CW-1:0]                  s1_ch_ff;
   logic [7:0]                     s1_byte_ff;
   logic                           s1_in_range_ff;
   nmea_sfc_pkg::chan_state_type   rd_data_ff;
   logic                           rd_valid_ff;
   logic                           fwd_hit_ff;
   nmea_sfc_pkg::chan_state_type   fwd_state_ff;

   // output register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [CW-1:0]                  rsp_ch_ff;
   logic [7:0]                     rsp_byte_ff;
   nmea_sfc_pkg::result_type       rsp_res_ff;

   logic                           req_accept;
   logic                           s1_fire;
   logic                           s1_valid_in;
   logic                           write_en;
   logic                           req_in_range;
   nmea_sfc_pkg::chan_state_type   cur_state;
   nmea_sfc_pkg::chan_state_type   nxt_state;
   nmea_sfc_pkg::result_type       step_res;

   // handshake
   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_accept   = req_bus.valid && req_bus.ready;
   assign req_in_range = 32'(req_bus.channel) < nmea_sfc_pkg::CHANNELS;
   assign write_en     = s1_fire && s1_in_range_ff;
   assign s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // current state: forwarded, read from memory, or zero if never written
   always_comb begin
      if (fwd_hit_ff) begin
         cur_state = fwd_state_ff;
      end else if (rd_valid_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   nmea_sfc_update u_update (
      .cur     (cur_state),
      .rx_byte (s1_byte_ff),
      .nxt     (nxt_state),
      .res     (step_res)
   );

   // state memory: read on acceptance, write back when the update stage retires
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= state_mem[req_bus.channel];
      end
      if (write_en) begin
         state_mem[s1_ch_ff] <= nxt_state;
         fwd_state_ff        <= nxt_state;
      end
   end

   // update stage registers and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
         fwd_hit_ff     <= 1'b0;
         rd_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (write_en) begin
            entry_valid_ff[s1_ch_ff] <= 1'b1;
         end
         if (req_accept) begin
            fwd_hit_ff  <= write_en && (s1_ch_ff == req_bus.channel);
            rd_valid_ff <= entry_valid_ff[req_bus.channel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff       <= req_bus.channel;
         s1_byte_ff     <= req_bus.rx_byte;
         s1_in_range_ff <= req_in_range;
      end
   end

   // output register
   assign rsp_valid_in = (write_en && step_res.valid) ? 1'b1 :
                         (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en && step_res.valid) begin
         rsp_ch_ff   <= s1_ch_ff;
         rsp_byte_ff <= s1_byte_ff;
         rsp_res_ff  <= step_res;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_channel   = rsp_ch_ff;
   assign rsp_bus.data_byte     = rsp_byte_ff;
   assign rsp_bus.first         = rsp_res_ff.first;
   assign rsp_bus.last          = rsp_res_ff.last;
   assign rsp_bus.sentence_type = rsp_res_ff.sentence_type;
   assign rsp_bus.status        = rsp_res_ff.status;

   // the opening dollar never carries a verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.first |-> !rsp_res_ff.last &&
         rsp_res_ff.status == nmea_sfc_pkg::STATUS_UNTYPED)
      else $error("first item carries a verdict");

   // a verdict only on the closing item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_res_ff.last |->
         rsp_res_ff.status == nmea_sfc_pkg::STATUS_UNTYPED)
      else $error("status without last");

   // a stalled update stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_ch_ff) && $stable(s1_byte_ff))
      else $error("update stage lost its item while stalled");

   // forwarding follows every write-back to the same channel as the accepted byte
   assert property (@(posedge clock) disable iff (reset)
      req_accept && write_en && s1_ch_ff == req_bus.channel |=> fwd_hit_ff)
      else $error("same-channel forwarding missed");

endmodule

`default_nettype wire
